// ===== rtl/aus_pkg.sv =====
package aus_pkg;

	// payload layout of the stream beats
	localparam int unsigned InDataW  = 80;
	localparam int unsigned OutDataW = 48;

	// packet checks
	localparam logic [7:0]  AcceptedCodec   = 8'd5;
	localparam logic [7:0]  MaxUnitsPerKind = 8'd31;
	localparam logic [15:0] HalfRange       = 16'h8000;

	// register indexes
	localparam logic CfgAudioSinkEn   = 1'b0;
	localparam logic CfgHapticsSinkEn = 1'b1;

	// result status codes
	localparam logic [2:0] StDelivered  = 3'd0;
	localparam logic [2:0] StNoSink     = 3'd1;
	localparam logic [2:0] StStale      = 3'd2;
	localparam logic [2:0] StStartSkip  = 3'd3;
	localparam logic [2:0] StBadCodec   = 3'd4;
	localparam logic [2:0] StEmpty      = 3'd5;
	localparam logic [2:0] StCountErr   = 3'd6;
	localparam logic [2:0] StSizeErr    = 3'd7;

	typedef struct packed {
		logic capture;   // latch the input header
		logic start;     // set up unit counters for a good packet
		logic load_err;  // put the error result in the output register
		logic emit;      // put the current unit result in the output register
	} aus_cmd_t;

	typedef struct packed {
		logic err_found; // header failed a check
		logic out_free;  // output register can take a result this cycle
		logic last_unit; // current unit is the final one of the packet
	} aus_stat_t;

endpackage

// ===== rtl/aus_ctrl.sv =====
module aus_ctrl
	import aus_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  aus_stat_t stat,
	output aus_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CHECK = 3'b010,
		S_RUN   = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.err_found) begin
					if (stat.out_free) begin
						cmd.load_err = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.start = 1'b1;
					state_d   = S_RUN;
				end
			end
			S_RUN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.last_unit) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/aus_dp.sv =====
module aus_dp
	import aus_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  aus_cmd_t            cmd,
	output aus_stat_t           stat,
	input  logic [InDataW-1:0]  in_data,
	input  logic                in_flag,
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic                cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OutDataW-1:0] out_data,
	output logic                out_flag,
	output logic                out_last
);

	// latched header
	logic [7:0]  codec_q;
	logic [15:0] first_q;
	logic [4:0]  nsrc_q;
	logic [4:0]  nfec_q;
	logic [7:0]  usize_q;
	logic [15:0] total_q;
	logic [15:0] payload_q;
	logic        haptic_q;

	// config
	logic aud_en_q, hap_en_q;

	// sequencing state
	logic        startup_q;
	logic        last_valid_q;
	logic [15:0] last_frame_q;

	// unit walk
	logic [5:0]  idx_q;
	logic [15:0] frame_q;
	logic [15:0] offset_q;
	logic [16:0] skipkey_q; // first_frame + k, no wrap

	// output register
	logic        oval_q;
	logic [2:0]  ostat_q;
	logic [15:0] oframe_q;
	logic        ofec_q;
	logic [15:0] ooff_q;
	logic [7:0]  olen_q;
	logic        ohap_q;
	logic        olast_q;

	logic [5:0]  count;
	logic [23:0] size_prod;
	logic [2:0]  err_code;
	logic        is_fec;
	logic        skip;
	logic [15:0] frame_gap;
	logic        newer;
	logic        stale;
	logic        sink;
	logic [2:0]  unit_status;
	logic        take_unit;
	logic [15:0] fec_base;

	assign count     = {1'b0, nsrc_q} + {1'b0, nfec_q};
	assign size_prod = {16'b0, usize_q} * {8'b0, total_q};
	assign fec_base  = first_q - {11'b0, nfec_q};

	always_comb begin
		err_code = StDelivered;
		if (codec_q != AcceptedCodec) begin
			err_code = StBadCodec;
		end else if (payload_q == 16'd0) begin
			err_code = StEmpty;
		end else if ({3'b0, nsrc_q} > MaxUnitsPerKind || {3'b0, nfec_q} > MaxUnitsPerKind
				|| {10'b0, count} != total_q) begin
			err_code = StCountErr;
		end else if ({8'b0, payload_q} != size_prod) begin
			err_code = StSizeErr;
		end
	end

	// per-unit decision
	assign is_fec    = idx_q >= {1'b0, nsrc_q};
	assign skip      = is_fec && startup_q && (skipkey_q < ({12'b0, nfec_q} + 17'd1));
	assign frame_gap = frame_q - last_frame_q;
	assign newer     = (frame_gap != 16'd0) && !frame_gap[15];
	assign stale     = last_valid_q && !newer;
	assign sink      = haptic_q ? hap_en_q : aud_en_q;
	assign take_unit = cmd.emit && !skip && !stale;

	always_comb begin
		if (skip) begin
			unit_status = StStartSkip;
		end else if (stale) begin
			unit_status = StStale;
		end else if (sink) begin
			unit_status = StDelivered;
		end else begin
			unit_status = StNoSink;
		end
	end

	assign stat.err_found = err_code != StDelivered;
	assign stat.out_free  = !oval_q || out_ready;
	assign stat.last_unit = (idx_q + 6'd1) == count;

	// header capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			codec_q   <= in_data[7:0];
			first_q   <= in_data[23:8];
			nsrc_q    <= in_data[28:24];
			nfec_q    <= in_data[33:29];
			usize_q   <= in_data[41:34];
			total_q   <= in_data[57:42];
			payload_q <= in_data[73:58];
			haptic_q  <= in_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aud_en_q <= 1'b0;
			hap_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CfgAudioSinkEn:   aud_en_q <= cfg_data;
				CfgHapticsSinkEn: hap_en_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_q    <= 1'b1;
			last_valid_q <= 1'b0;
			last_frame_q <= 16'd0;
		end else begin
			if (cmd.start && first_q > HalfRange) begin
				startup_q <= 1'b0;
			end
			if (take_unit) begin
				last_valid_q <= 1'b1;
				last_frame_q <= frame_q;
			end
		end
	end

	// unit counters
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q     <= 6'd0;
			offset_q  <= 16'd0;
			skipkey_q <= {1'b0, first_q};
			frame_q   <= (nsrc_q == 5'd0) ? fec_base : first_q;
		end else if (cmd.emit) begin
			idx_q    <= idx_q + 6'd1;
			offset_q <= offset_q + {8'b0, usize_q};
			if (is_fec) begin
				skipkey_q <= skipkey_q + 17'd1;
			end
			if ((idx_q + 6'd1) == {1'b0, nsrc_q}) begin
				frame_q <= fec_base;
			end else begin
				frame_q <= frame_q + 16'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (cmd.emit || cmd.load_err) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			ostat_q  <= err_code;
			oframe_q <= first_q;
			ofec_q   <= 1'b0;
			ooff_q   <= 16'd0;
			olen_q   <= 8'd0;
			ohap_q   <= haptic_q;
			olast_q  <= 1'b1;
		end else if (cmd.emit) begin
			ostat_q  <= unit_status;
			oframe_q <= frame_q;
			ofec_q   <= is_fec;
			ooff_q   <= offset_q;
			olen_q   <= usize_q;
			ohap_q   <= haptic_q;
			olast_q  <= stat.last_unit;
		end
	end

	assign out_valid = oval_q;
	assign out_data  = {4'b0, olen_q, ooff_q, ofec_q, oframe_q, ostat_q};
	assign out_flag  = ohap_q;
	assign out_last  = olast_q;

endmodule

// ===== rtl/audio_unit_sequencer.sv =====
// Sequence: a header beat is taken in the idle state and checked in the
// check state; an error result goes into the output register from the check
// state once that register is free, the unit results of a good packet from
// the run state. The unit walk gives one result per cycle while the output
// is not back-pressured; a new header is taken once the last packet is done.
// Reset: arst_n low clears the sink enables, the last accepted frame and its
// valid flag, sets startup, and empties the output register.
module audio_unit_sequencer
	import aus_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// header beats
	input  logic                s_tvalid,
	output logic                s_tready,
	// [7:0] codec_id, [23:8] first_frame, [28:24] source_units,
	// [33:29] fec_units, [41:34] unit_bytes, [57:42] units_total,
	// [73:58] payload_bytes, [79:74] zero
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                s_tuser,   // [0] haptic_flag
	// unit result beats
	output logic                m_tvalid,
	input  logic                m_tready,
	// [2:0] status, [18:3] unit_frame, [19] unit_is_fec,
	// [35:20] unit_offset, [43:36] unit_length, [47:44] zero
	output logic [OutDataW-1:0] m_tdata,
	output logic                m_tuser,   // [0] unit_haptic
	output logic                m_tlast,   // final result of the packet
	// register writes
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic                cfg_data
);

	aus_cmd_t  cmd;
	aus_stat_t stat;

	// Sequencer: idle -> check -> error result, or walk units one per free slot.
	aus_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Header checks, frame/offset counters, stale tracking and the result
	// register; a finished result waits there while the next header is taken.
	aus_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.in_flag   (s_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_flag  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ===== tb/aus_checker.sv =====
module aus_checker
	import aus_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,
	input  logic                m_tuser,
	input  logic                m_tlast,
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic                cfg_data,
	output int                  errors,
	output int                  pending,
	output int                  units_checked
);

	localparam int MaxShown = 100;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] frame;
		logic        fec;
		logic [15:0] offset;
		logic [7:0]  length;
		logic        haptic;
		logic        last;
	} unit_res_t;

	unit_res_t   unit_q[$];
	logic        audio_en;
	logic        haptic_en;
	logic [15:0] last_frame;
	logic        frame_valid;
	logic        in_startup;

	// serial number order over 16 bits; indices half a range apart are unordered
	function automatic logic is_newer(logic [15:0] a, logic [15:0] b);
		if (a == b)
			return 1'b0;
		if (a < b)
			return (b - a) > HalfRange;
		return (a - b) < HalfRange;
	endfunction

	function automatic string unit_str(unit_res_t u);
		return $sformatf("st=%0d frame=%0d fec=%0d off=%0d len=%0d hap=%0d last=%0d",
			u.status, u.frame, u.fec, u.offset, u.length, u.haptic, u.last);
	endfunction

	task automatic expand_packet(input logic [InDataW-1:0] hdr, input logic hap);
		int unsigned codec, first, nsrc, nfec, usize, total, payload, count, i, k;
		logic        bad;
		logic        sink;
		logic        skip;
		logic [2:0]  err;
		unit_res_t   r;
		codec   = hdr[7:0];
		first   = hdr[23:8];
		nsrc    = hdr[28:24];
		nfec    = hdr[33:29];
		usize   = hdr[41:34];
		total   = hdr[57:42];
		payload = hdr[73:58];
		sink    = hap ? haptic_en : audio_en;
		bad     = 1'b1;
		err     = StBadCodec;
		if (codec != AcceptedCodec)
			err = StBadCodec;
		else if (payload == 0)
			err = StEmpty;
		else if (nsrc > MaxUnitsPerKind || nfec > MaxUnitsPerKind || nsrc + nfec != total)
			err = StCountErr;
		else if (payload != usize * total)
			err = StSizeErr;
		else
			bad = 1'b0;

		if (bad) begin
			r = '{status: err, frame: 16'(first), fec: 1'b0, offset: 16'd0, length: 8'd0,
				haptic: hap, last: 1'b1};
			unit_q.push_back(r);
			return;
		end

		if (first > HalfRange)
			in_startup = 1'b0;

		count = nsrc + nfec;
		for (i = 0; i < count; i++) begin
			r.fec    = (i >= nsrc);
			r.offset = 16'(usize * i);
			r.length = 8'(usize);
			r.haptic = hap;
			r.last   = (i + 1 == count);
			skip     = 1'b0;
			if (i < nsrc) begin
				r.frame = 16'(first + i);
			end else begin
				// FEC units cover the frames just before first_frame
				k       = i - nsrc;
				r.frame = 16'(first + 32'h10000 - nfec + k);
				skip    = in_startup && (first + k < nfec + 1);
			end
			if (skip) begin
				r.status = StStartSkip;
			end else if (frame_valid && !is_newer(r.frame, last_frame)) begin
				r.status = StStale;
			end else begin
				frame_valid = 1'b1;
				last_frame  = r.frame;
				r.status    = sink ? StDelivered : StNoSink;
			end
			unit_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		unit_res_t got;
		unit_res_t want;
		if (!arst_n) begin
			unit_q.delete();
			audio_en      = 1'b0;
			haptic_en     = 1'b0;
			last_frame    = 16'd0;
			frame_valid   = 1'b0;
			in_startup    = 1'b1;
			errors        = 0;
			units_checked = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CfgAudioSinkEn)
					audio_en = cfg_data;
				else if (cfg_index == CfgHapticsSinkEn)
					haptic_en = cfg_data;
			end
			if (s_tvalid && s_tready)
				expand_packet(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				got = '{status: m_tdata[2:0], frame: m_tdata[18:3], fec: m_tdata[19],
					offset: m_tdata[35:20], length: m_tdata[43:36], haptic: m_tuser,
					last: m_tlast};
				if (unit_q.size() == 0) begin
					errors++;
					if (errors <= MaxShown)
						$display("%0t: unexpected beat, expected none, got %s",
							$time, unit_str(got));
				end else begin
					want = unit_q.pop_front();
					units_checked++;
					if (got !== want) begin
						errors++;
						if (errors <= MaxShown)
							$display("%0t: mismatch, expected %s, got %s",
								$time, unit_str(want), unit_str(got));
					end
				end
			end
		end
		pending = unit_q.size();
	end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import aus_pkg::*;

	localparam int PhaseItems    = 45;     // random headers per sink setting
	localparam int NumPhases     = 4;
	localparam int LongHold      = 400;    // receiver stall long enough to back up the block
	localparam int WatchdogLimit = 4000;   // cycles with no beat, config write or acceptance

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata   = '0;
	logic                s_tuser   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tuser;
	logic                m_tlast;
	logic                cfg_wr_en = 1'b0;
	logic                cfg_index = 1'b0;
	logic                cfg_data  = 1'b0;

	int          errors;
	int          pending;
	int          units_checked;
	int          headers_sent = 0;
	int          stall_cycles = 0;
	bit          calm         = 1'b0;  // no idling on either side
	bit          long_hold    = 1'b0;  // request one long receiver stall
	logic [15:0] next_frame   = 16'd0; // sender's idea of the next in-order frame

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	audio_unit_sequencer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	aus_checker CHK (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.units_checked(units_checked)
	);

	// Offer one header beat and hold it until taken. valid stays high into the
	// next call unless a random gap is inserted here.
	task automatic send_header(input logic [7:0] codec, input logic [15:0] first,
		input logic [4:0] nsrc, input logic [4:0] nfec, input logic [7:0] usize,
		input logic [15:0] total, input logic [15:0] payload, input logic hap);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, payload, total, usize, nfec, nsrc, first, codec};
		s_tuser  <= hap;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		headers_sent++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// consistent header: counts add up and payload matches unit size
	task automatic send_good(input logic [15:0] first, input logic [4:0] nsrc,
		input logic [4:0] nfec, input logic [7:0] usize, input logic hap);
		logic [15:0] total;
		logic [15:0] payload;
		total   = nsrc + nfec;
		payload = usize * total;
		send_header(AcceptedCodec, first, nsrc, nfec, usize, total, payload, hap);
	endtask

	task automatic write_cfg(input logic idx, input logic val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering and wait until every predicted unit has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_sinks(input logic audio, input logic haptic);
		drain();
		write_cfg(CfgAudioSinkEn, audio);
		write_cfg(CfgHapticsSinkEn, haptic);
	endtask

	// Mostly in-order packets with random contents; some jump or replay frames
	// (stale drops), some break one header check, a few are pure noise.
	task automatic send_random_packet();
		int          kind;
		logic [7:0]  codec;
		logic [15:0] first;
		logic [4:0]  ns;
		logic [4:0]  nf;
		logic [7:0]  ub;
		logic [15:0] total;
		logic [15:0] payload;
		kind = $urandom_range(0, 99);
		ns   = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4));
		nf   = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
		if (ns == 0 && nf == 0)
			ns = 5'd1;
		ub    = 8'($urandom_range(1, 255));
		codec = AcceptedCodec;
		first = next_frame;
		if (kind >= 75 && kind < 83)
			first = 16'($urandom);
		else if (kind >= 83 && kind < 88)
			first = next_frame - 16'($urandom_range(1, 40));
		total   = ns + nf;
		payload = ub * total;
		if (kind >= 88 && kind < 95) begin
			case ($urandom_range(0, 3))
				0: codec   = AcceptedCodec ^ 8'($urandom_range(1, 255));
				1: payload = 16'd0;
				2: total   = total + 16'($urandom_range(1, 100));
				default: payload = payload + 16'($urandom_range(1, 100));
			endcase
		end else if (kind >= 95) begin
			codec   = 8'($urandom);
			first   = 16'($urandom);
			ns      = 5'($urandom);
			nf      = 5'($urandom);
			ub      = 8'($urandom);
			total   = 16'($urandom);
			payload = 16'($urandom);
		end
		if (kind < 88)
			next_frame = first + ns + 16'($urandom_range(0, 2));
		send_header(codec, first, ns, nf, ub, total, payload, 1'($urandom_range(0, 1)));
	endtask

	// Receiver: random ready bursts, a single long stall on request, and
	// steady ready once the run goes calm.
	initial begin
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				m_tready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// watchdog: a hung handshake ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WatchdogLimit) begin
				$display("%0t: no progress for %0d cycles, %0d units outstanding",
					$time, stall_cycles, pending);
				$display("[audio_unit_sequencer] ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sinks off (reset values), written explicitly
		write_cfg(CfgAudioSinkEn, 1'b0);
		write_cfg(CfgHapticsSinkEn, 1'b0);

		// header checks, in priority order, at field extremes
		send_header(8'd0, 16'h0000, 5'd1, 5'd0, 8'd1, 16'd1, 16'd1, 1'b0);
		send_header(8'hFF, 16'hFFFF, 5'd31, 5'd31, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_header(AcceptedCodec, 16'd7, 5'd2, 5'd1, 8'd0, 16'd3, 16'd0, 1'b0);
		send_header(AcceptedCodec, 16'd7, 5'd2, 5'd1, 8'd4, 16'd4, 16'd16, 1'b1);
		send_header(AcceptedCodec, 16'd7, 5'd2, 5'd1, 8'd4, 16'd3, 16'd13, 1'b0);
		// no units declared but a nonzero payload: size check fails
		send_header(AcceptedCodec, 16'd7, 5'd0, 5'd0, 8'd9, 16'd0, 16'd5, 1'b1);

		// startup: FEC at frame 0 or below is skipped, other FEC behind the last frame goes stale
		send_good(16'd0, 5'd2, 5'd3, 8'd10, 1'b0);
		send_good(16'd2, 5'd3, 5'd4, 8'd20, 1'b1);
		send_good(16'd5, 5'd0, 5'd4, 8'd8, 1'b0);
		send_good(16'd5, 5'd1, 5'd0, 8'd2, 1'b1);
		// first_frame at exactly half range keeps startup on
		send_good(16'd32768, 5'd2, 5'd0, 8'd3, 1'b0);
		// half a range behind the last frame: not newer, dropped; FEC skipped
		send_good(16'd1, 5'd1, 5'd1, 8'd2, 1'b1);
		// past half range: startup ends, first unit repeats the last frame
		send_good(16'd32769, 5'd4, 5'd2, 8'd255, 1'b0);
		// frame index wrap
		send_good(16'hFFFE, 5'd4, 5'd1, 8'd1, 1'b1);
		// largest packet
		send_good(16'd2, 5'd31, 5'd31, 8'd255, 1'b0);
		send_good(16'd40, 5'd31, 5'd0, 8'd1, 1'b1);
		send_good(16'd40, 5'd0, 5'd1, 8'd3, 1'b0);
		next_frame = 16'd71;

		// random part over the remaining sink settings, calm in the last one
		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				0: set_sinks(1'b1, 1'b1);
				1: set_sinks(1'b1, 1'b0);
				2: set_sinks(1'b0, 1'b1);
				default: set_sinks(1'b1, 1'b1);
			endcase
			calm = (p == NumPhases - 1);
			for (int j = 0; j < PhaseItems; j++) begin
				if (p == 1 && j == 10)
					long_hold = 1'b1;  // sender keeps pushing while output is stuck
				if (p == 2 && j == 20)
					drain();           // sender goes quiet until the block is empty
				send_random_packet();
			end
		end

		drain();
		repeat (16) @(posedge clk);

		$display("run: %0d headers over five sink settings (malformed, stale, startup, wrap)",
			headers_sent);
		$display("run: %0d unit beats compared, with long output stall and full drain",
			units_checked);
		if (errors == 0 && pending == 0)
			$display("[audio_unit_sequencer] OK");
		else
			$display("[audio_unit_sequencer] ERROR");
		$finish;
	end

endmodule

// ===== audio_unit_sequencer.f =====
rtl/aus_pkg.sv
rtl/aus_ctrl.sv
rtl/aus_dp.sv
rtl/audio_unit_sequencer.sv
tb/aus_checker.sv
tb/tb_top.sv
